/* sv/cap_apwm_pkg.sv */
package cap_apwm_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned CtrlWidth = 16;
    localparam int unsigned OffsetWidth = 6;
    localparam int unsigned KindWidth = 2;

    typedef logic [DataWidth-1:0] data_t;
    typedef logic [CtrlWidth-1:0] ctrl_t;
    typedef logic [OffsetWidth-1:0] offset_t;
    typedef logic [KindWidth-1:0] kind_t;

    // item kinds
    localparam kind_t KIND_TICK = 2'd0;
    localparam kind_t KIND_READ = 2'd1;
    localparam kind_t KIND_WRITE = 2'd2;

    // register byte offsets
    localparam offset_t OFF_COUNTER = 6'h00;
    localparam offset_t OFF_APRD = 6'h08;
    localparam offset_t OFF_ACMP = 6'h0C;
    localparam offset_t OFF_SPRD = 6'h10;
    localparam offset_t OFF_SCMP = 6'h14;
    localparam offset_t OFF_CTRL = 6'h2A;

    // control word bit positions
    localparam int unsigned CTRL_RUN_BIT = 4;
    localparam int unsigned CTRL_APWM_BIT = 9;
    localparam int unsigned CTRL_POLLOW_BIT = 10;

endpackage

/* sv/capture_unit_apwm_output_top.sv */
// Auxiliary PWM output with shadowed period and compare. Each transfer on the
// input is a tick, a register read or a register write, and gives exactly one
// result transfer holding the read data, the pin level after the item and a
// period boundary flag. The whole item is resolved in the cycle it is taken
// (one 32-bit increment, the period equality compare and the compare-level
// check) and lands in a single result register, so one item per clock is
// sustained; the input is held off only while that result register is full
// and not being taken.
module capture_unit_apwm_output_top
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cap_apwm_pkg::kind_t    kind,
    input  cap_apwm_pkg::offset_t  reg_offset,
    input  cap_apwm_pkg::data_t    write_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cap_apwm_pkg::data_t    read_data,
    output logic                   pwm_level,
    output logic                   period_event
);
    import cap_apwm_pkg::*;

    data_t counter_reg, counter_next;
    data_t aprd_reg, aprd_next;
    data_t acmp_reg, acmp_next;
    data_t sprd_reg, sprd_next;
    data_t scmp_reg, scmp_next;
    ctrl_t ctrl_reg, ctrl_next;

    logic  out_valid_reg;
    data_t read_data_reg, read_data_next;
    logic  pwm_level_reg, pwm_level_next;
    logic  event_reg, event_next;

    data_t counter_inc;
    logic  in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer = in_valid && in_ready;
    assign counter_inc = counter_reg + data_t'(1);

    always_comb
    begin
        counter_next = counter_reg;
        aprd_next = aprd_reg;
        acmp_next = acmp_reg;
        sprd_next = sprd_reg;
        scmp_next = scmp_reg;
        ctrl_next = ctrl_reg;
        read_data_next = '0;
        event_next = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                if (ctrl_reg[CTRL_RUN_BIT])
                begin
                    // boundary only with a nonzero period, else plain wrap
                    if ((aprd_reg != '0) && (counter_inc == aprd_reg))
                    begin
                        counter_next = '0;
                        aprd_next = sprd_reg;
                        acmp_next = scmp_reg;
                        event_next = 1'b1;
                    end
                    else
                    begin
                        counter_next = counter_inc;
                    end
                end
            end
            KIND_READ:
            begin
                case (reg_offset)
                    OFF_COUNTER: read_data_next = counter_reg;
                    OFF_APRD:    read_data_next = aprd_reg;
                    OFF_ACMP:    read_data_next = acmp_reg;
                    OFF_SPRD:    read_data_next = sprd_reg;
                    OFF_SCMP:    read_data_next = scmp_reg;
                    OFF_CTRL:    read_data_next = data_t'(ctrl_reg);
                    default:     read_data_next = '0;
                endcase
            end
            KIND_WRITE:
            begin
                case (reg_offset)
                    OFF_COUNTER: counter_next = write_data;
                    OFF_APRD:    aprd_next = write_data;
                    OFF_ACMP:    acmp_next = write_data;
                    OFF_SPRD:    sprd_next = write_data;
                    OFF_SCMP:    scmp_next = write_data;
                    OFF_CTRL:    ctrl_next = write_data[CtrlWidth-1:0];
                    default:     ;
                endcase
            end
            default: ;
        endcase

        // pin level from the state this item leaves behind
        if (ctrl_next[CTRL_APWM_BIT])
        begin
            pwm_level_next = (counter_next < acmp_next) ^ ctrl_next[CTRL_POLLOW_BIT];
        end
        else
        begin
            pwm_level_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            aprd_reg <= '0;
            acmp_reg <= '0;
            sprd_reg <= '0;
            scmp_reg <= '0;
            ctrl_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                counter_reg <= counter_next;
                aprd_reg <= aprd_next;
                acmp_reg <= acmp_next;
                sprd_reg <= sprd_next;
                scmp_reg <= scmp_next;
                ctrl_reg <= ctrl_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            read_data_reg <= read_data_next;
            pwm_level_reg <= pwm_level_next;
            event_reg <= event_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign pwm_level = pwm_level_reg;
    assign period_event = event_reg;

endmodule
